@@ rtl/crcc_pkg.sv @@
// shared types, constants and helpers for the rank/coordinate converter
// no dependencies
`default_nettype none
package crcc_pkg;

  localparam int MAX_DIM   = 1024;
  localparam int DW        = 11;
  localparam int CW        = 10;
  localparam int RW        = 30;
  localparam int DIV1_STEPS = RW;
  localparam int DIV2_STEPS = 20;
  localparam int N_CELLS   = DIV1_STEPS + DIV2_STEPS;

  localparam logic [2:0] REG_DIM_X    = 3'd0;
  localparam logic [2:0] REG_DIM_Y    = 3'd1;
  localparam logic [2:0] REG_DIM_Z    = 3'd2;
  localparam logic [2:0] REG_PERIODIC = 3'd3;
  localparam logic [2:0] REG_ORDER    = 3'd4;

  localparam logic OP_RANK2COORD = 1'b0;
  localparam logic OP_COORD2RANK = 1'b1;

  typedef struct packed {
    logic          vld;
    logic          op;
    logic          nul;
    logic [2:0]    ord;
    logic [RW-1:0] rank;
    logic [RW-1:0] num;
    logic [DW-1:0] rem;
    logic [DW-1:0] dv;
    logic [DW-1:0] dv2;
    logic [CW-1:0] cf;
  } cell_t;

  // axis index (0 x, 1 y, 2 z) of fastest, middle, slowest axis
  function automatic logic [5:0] axis_seq(input logic [2:0] ord);
    logic [5:0] s;
    case (ord)
      3'd1:    s = {2'd1, 2'd2, 2'd0};
      3'd2:    s = {2'd0, 2'd1, 2'd2};
      3'd3:    s = {2'd0, 2'd2, 2'd1};
      3'd4:    s = {2'd1, 2'd0, 2'd2};
      3'd5:    s = {2'd2, 2'd0, 2'd1};
      default: s = {2'd2, 2'd1, 2'd0};
    endcase
    return s; // {slow, mid, fast}
  endfunction

  function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] d);
    logic [DW-1:0] r;
    if (d == '0) r = DW'(1);
    else if (d > DW'(MAX_DIM)) r = DW'(MAX_DIM);
    else r = d;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/cartesian_rank_coord_converter_unit.sv @@
// top level: config registers, front stages, divider cell chain, output register
// depends on crcc_pkg and crcc_cell
//
// channel | dir | handshake              | payload
// in      | in  | in_tvalid/in_tready    | tdata rank,x,y,z; tuser opcode
// out     | out | out_tvalid/out_tready  | tdata rank,x,y,z; tuser null
// cfg     | in  | cfg_valid/cfg_ready    | cfg_addr index, cfg_data value
//
// one item a cycle while the output is taken; 3 front stages, 50 division cells, 1 output register
// the cell chain (one quotient bit per cell) sets the latency
// synchronous active-low reset empties the pipe; config resets to its defaults
// when the output register holds an item nobody takes, the whole pipe holds
`default_nettype none
module cartesian_rank_coord_converter_unit
  import crcc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // rank_in[29:0], coord_x_in, coord_y_in, coord_z_in
  input  wire logic        in_tuser,   // opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // rank_res[29:0], coord_x_out, coord_y_out, coord_z_out
  output logic             out_tuser,  // null_result
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [10:0] cfg_data
);
  logic [DW-1:0] dim_r [3];
  logic [2:0]    per_r, ord_r;
  logic          en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r[0] <= DW'(1);
      dim_r[1] <= DW'(1);
      dim_r[2] <= DW'(1);
      per_r    <= '0;
      ord_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_DIM_X:    dim_r[0] <= cfg_data;
        REG_DIM_Y:    dim_r[1] <= cfg_data;
        REG_DIM_Z:    dim_r[2] <= cfg_data;
        REG_PERIODIC: per_r    <= cfg_data[2:0];
        REG_ORDER:    ord_r    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // stage 1: clamp, check and wrap coordinates, order axes
  logic [DW-1:0] dc [3];
  logic [CW-1:0] cw [3];
  logic [2:0]    bad;
  logic [5:0]    seq;
  logic [11:0]   cin [3];

  assign cin[0] = in_tdata[41:30];
  assign cin[1] = in_tdata[53:42];
  assign cin[2] = in_tdata[65:54];
  assign seq    = axis_seq(ord_r);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dc[i]  = clamp_dim(dim_r[i]);
      bad[i] = 1'b0;
      cw[i]  = cin[i][CW-1:0];
      if (cin[i][11]) begin
        // only -1 on a wrapping axis is allowed below zero
        if (per_r[i] && cin[i] == 12'hFFF) cw[i] = CW'(dc[i] - DW'(1));
        else bad[i] = 1'b1;
      end else if ({1'b0, cin[i]} >= {2'b00, dc[i]}) begin
        if (per_r[i] && {1'b0, cin[i]} == {2'b00, dc[i]}) cw[i] = '0;
        else bad[i] = 1'b1;
      end
    end
  end

  logic          v1_r, op1_r, nul1_r;
  logic [RW-1:0] r1_r;
  logic [CW-1:0] cf1_r, cm1_r, cs1_r;
  logic [DW-1:0] df1_r, dm1_r, ds1_r;
  logic [2:0]    o1_r;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r   <= in_tvalid;
      op1_r  <= in_tuser;
      nul1_r <= |bad;
      r1_r   <= in_tdata[29:0];
      cf1_r  <= cw[seq[1:0]];
      cm1_r  <= cw[seq[3:2]];
      cs1_r  <= cw[seq[5:4]];
      df1_r  <= dc[seq[1:0]];
      dm1_r  <= dc[seq[3:2]];
      ds1_r  <= dc[seq[5:4]];
      o1_r   <= ord_r;
    end
  end

  // stage 2: slow*mid + mid coordinate, fast*mid extent
  logic          v2_r, op2_r, nul2_r;
  logic [RW-1:0] r2_r;
  logic [19:0]   m2_r;
  logic [20:0]   dd2_r;
  logic [CW-1:0] cf2_r;
  logic [DW-1:0] df2_r, dm2_r, ds2_r;
  logic [2:0]    o2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r   <= v1_r;
      op2_r  <= op1_r;
      nul2_r <= nul1_r;
      r2_r   <= r1_r;
      m2_r   <= 20'(cs1_r * dm1_r + {11'd0, cm1_r});
      dd2_r  <= 21'(df1_r * dm1_r);
      cf2_r  <= cf1_r;
      df2_r  <= df1_r;
      dm2_r  <= dm1_r;
      ds2_r  <= ds1_r;
      o2_r   <= o1_r;
    end
  end

  // stage 3: linear rank and grid size
  logic          v3_r, op3_r, nul3_r;
  logic [RW-1:0] r3_r, rank3_r;
  logic [30:0]   size3_r;
  logic [DW-1:0] df3_r, dm3_r;
  logic [2:0]    o3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r    <= v2_r;
      op3_r   <= op2_r;
      nul3_r  <= nul2_r;
      r3_r    <= r2_r;
      rank3_r <= RW'(m2_r * df2_r + {21'd0, cf2_r});
      size3_r <= 31'(dd2_r * ds2_r);
      df3_r   <= df2_r;
      dm3_r   <= dm2_r;
      o3_r    <= o2_r;
    end
  end

  // chain head: range check and load of the first division
  cell_t head;
  cell_t mid;
  cell_t link [N_CELLS];

  always_comb begin
    head.vld  = v3_r;
    head.op   = op3_r;
    head.nul  = (op3_r == OP_COORD2RANK) ? nul3_r : ({1'b0, r3_r} >= size3_r);
    head.ord  = o3_r;
    head.rank = rank3_r;
    head.num  = r3_r;
    head.rem  = '0;
    head.dv   = df3_r;
    head.dv2  = dm3_r;
    head.cf   = '0;
  end

  // between the two divisions: fast remainder kept, quotient reloaded
  always_comb begin
    mid     = link[DIV1_STEPS-1];
    mid.cf  = link[DIV1_STEPS-1].rem[CW-1:0];
    mid.rem = '0;
    mid.dv  = link[DIV1_STEPS-1].dv2;
    mid.num = {link[DIV1_STEPS-1].num[DIV2_STEPS-1:0], {(RW-DIV2_STEPS){1'b0}}};
  end

  for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
    if (k == 0) begin : g_a
      crcc_cell u_cell (.clk, .rst_n, .en, .d_in(head), .d_out(link[k]));
    end else if (k == DIV1_STEPS) begin : g_b
      crcc_cell u_cell (.clk, .rst_n, .en, .d_in(mid), .d_out(link[k]));
    end else begin : g_c
      crcc_cell u_cell (.clk, .rst_n, .en, .d_in(link[k-1]), .d_out(link[k]));
    end
  end

  // output mapping back to x, y, z
  cell_t         tl;
  logic [5:0]    oseq;
  logic [CW-1:0] oc [3];
  logic [RW-1:0] orank;

  assign tl   = link[N_CELLS-1];
  assign oseq = axis_seq(tl.ord);

  always_comb begin
    oc[0] = '0;
    oc[1] = '0;
    oc[2] = '0;
    orank = '0;
    if (!tl.nul) begin
      if (tl.op == OP_RANK2COORD) begin
        oc[oseq[1:0]] = tl.cf;
        oc[oseq[3:2]] = tl.rem[CW-1:0];
        oc[oseq[5:4]] = tl.num[CW-1:0];
      end else begin
        orank = tl.rank;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (en) begin
      out_tvalid <= tl.vld;
      out_tdata  <= {4'd0, oc[2], oc[1], oc[0], orank};
      out_tuser  <= tl.nul;
    end
  end

endmodule
`default_nettype wire

@@ rtl/crcc_cell.sv @@
// one restoring division step of the divider chain, registered
// depends on crcc_pkg
`default_nettype none
module crcc_cell
  import crcc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire cell_t d_in,
  output cell_t      d_out
);
  cell_t         q_r, q_nxt;
  logic [DW-1:0] rem_ext;

  always_comb begin
    q_nxt   = d_in;
    rem_ext = {d_in.rem[DW-2:0], d_in.num[RW-1]};
    q_nxt.num = {d_in.num[RW-2:0], 1'b0};
    if (rem_ext >= d_in.dv) begin
      q_nxt.rem    = rem_ext - d_in.dv;
      q_nxt.num[0] = 1'b1;
    end else begin
      q_nxt.rem = rem_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign d_out = q_r;
endmodule
`default_nettype wire

@@ test/tb_cartesian_rank_coord_converter_unit.sv @@
// self-checking testbench for cartesian_rank_coord_converter_unit
// depends on crcc_pkg and the converter rtl; directed table, then random config phases
`default_nettype none
module tb_cartesian_rank_coord_converter_unit;
  import crcc_pkg::*;

  // expected or observed contents of one result item
  typedef struct {
    logic [29:0] rank;
    logic [9:0]  cx;
    logic [9:0]  cy;
    logic [9:0]  cz;
    logic        nul;
  } conv_t;

  typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_t;

  // one line of the directed table
  typedef struct {
    row_kind_t          kind;
    logic               chk;    // expected result typed in below
    logic [2:0]         sel;    // register index or opcode
    logic [29:0]        rank;   // rank, or register value
    logic signed [11:0] x;
    logic signed [11:0] y;
    logic signed [11:0] z;
    conv_t              res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;   // rank_in[29:0], coord_x_in, coord_y_in, coord_z_in
  logic        in_tuser = 1'b0; // opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // rank_res[29:0], coord_x_out, coord_y_out, coord_z_out
  logic        out_tuser;       // null_result
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_addr = '0;
  logic [10:0] cfg_data = '0;

  cartesian_rank_coord_converter_unit dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the configuration registers
  logic [10:0] grid_dim [3];
  logic [2:0]  wrap_mask;
  logic [2:0]  order_sel;

  conv_t pending_results [$];
  row_t  steps [$];
  int    fail_cnt = 0;
  int    items_sent = 0;
  int    results_seen = 0;
  int    cfg_writes = 0;
  bit    no_idle = 1'b0;   // burst stretch without gaps on either side

  // expected result of one query under the shadow configuration
  function automatic conv_t convert(logic op, logic [29:0] rank,
                                    logic signed [11:0] x, logic signed [11:0] y,
                                    logic signed [11:0] z);
    conv_t       r;
    longint      d [3];
    longint      c [3];
    longint      v;
    longint      rr;
    int          fa, mi, sl;
    bit          bad;
    logic signed [11:0] ci [3];
    r = '{rank: '0, cx: '0, cy: '0, cz: '0, nul: 1'b0};
    for (int i = 0; i < 3; i++) begin
      if (grid_dim[i] == 0) d[i] = 1;
      else if (grid_dim[i] > 1024) d[i] = 1024;
      else d[i] = longint'(grid_dim[i]);
      c[i] = 0;
    end
    // fastest, middle, slowest axis
    case (order_sel)
      3'd1: begin fa = 0; mi = 2; sl = 1; end
      3'd2: begin fa = 2; mi = 1; sl = 0; end
      3'd3: begin fa = 1; mi = 2; sl = 0; end
      3'd4: begin fa = 2; mi = 0; sl = 1; end
      3'd5: begin fa = 1; mi = 0; sl = 2; end
      default: begin fa = 0; mi = 1; sl = 2; end
    endcase
    if (op == OP_RANK2COORD) begin
      rr = longint'(rank);
      if (rr >= d[0] * d[1] * d[2]) begin
        r.nul = 1'b1;
      end else begin
        c[fa] = rr % d[fa];
        rr = rr / d[fa];
        c[mi] = rr % d[mi];
        rr = rr / d[mi];
        c[sl] = rr;
        r.cx = c[0][9:0];
        r.cy = c[1][9:0];
        r.cz = c[2][9:0];
      end
      return r;
    end
    ci[0] = x; ci[1] = y; ci[2] = z;
    bad = 1'b0;
    for (int i = 0; i < 3; i++) begin
      v = longint'(ci[i]);
      if (!bad) begin
        // periodic axes wrap -1 and exactly the extent
        if (v < 0) begin
          if (!wrap_mask[i] || v != -1) bad = 1'b1;
          else v = d[i] - 1;
        end
        if (!bad && v >= d[i]) begin
          if (!wrap_mask[i] || v > d[i]) bad = 1'b1;
          else v = 0;
        end
        c[i] = v;
      end
    end
    r.nul = bad;
    if (!bad) begin
      rr = (c[sl] * d[mi] + c[mi]) * d[fa] + c[fa];
      r.rank = rr[29:0];
    end
    return r;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [10:0] val);
    bit ok;
    // block must be drained first
    wait (pending_results.size() == 0);
    repeat (60) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DIM_X:    grid_dim[0] = val;
      REG_DIM_Y:    grid_dim[1] = val;
      REG_DIM_Z:    grid_dim[2] = val;
      REG_PERIODIC: wrap_mask   = val[2:0];
      REG_ORDER:    order_sel   = val[2:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // drive one item, wait for acceptance and queue its expected result
  task automatic send_item(input logic op, input logic [29:0] rank,
                           input logic signed [11:0] x, input logic signed [11:0] y,
                           input logic signed [11:0] z, input bit typed,
                           input conv_t typed_res);
    int gap;
    bit ok;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'b0, z, y, x, rank};
    do begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
    end while (!ok);
    pending_results.push_back(typed ? typed_res : convert(op, rank, x, y, z));
    items_sent++;
  endtask

  task automatic add_row(input row_kind_t k, input logic [2:0] sel, input logic [29:0] rank,
                         input int x, input int y, input int z, input bit chk,
                         input conv_t res);
    row_t r;
    r.kind = k; r.sel = sel; r.rank = rank;
    r.x = x[11:0]; r.y = y[11:0]; r.z = z[11:0];
    r.chk = chk; r.res = res;
    steps.push_back(r);
  endtask

  // pick a coordinate near the interesting points of one axis
  function automatic logic signed [11:0] pick_coord(input logic [10:0] dim_raw);
    int d;
    d = (dim_raw == 0) ? 1 : (dim_raw > 1024 ? 1024 : int'(dim_raw));
    case ($urandom_range(0, 9))
      0: return -12'sd1;
      1: return 12'(d);
      2: return 12'(d + 1);
      3: return 12'(d - 1);
      4: return 12'($urandom_range(0, 4095));
      5: return -12'sd2;
      default: return 12'($urandom_range(0, d - 1));
    endcase
  endfunction

  // result side: random stall per item, check against the oldest expectation
  initial begin
    int    stall;
    bit    got;
    conv_t seen;
    conv_t want;
    wait (rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do begin
        @(negedge clk);
        got = out_tvalid;
        seen.rank = out_tdata[29:0];
        seen.cx   = out_tdata[39:30];
        seen.cy   = out_tdata[49:40];
        seen.cz   = out_tdata[59:50];
        seen.nul  = out_tuser;
        @(posedge clk);
      end while (!got);
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: result item with nothing expected, rank %h null %b", $time,
                 seen.rank, seen.nul);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (seen.rank !== want.rank) begin
          $display("%0t: rank result expected %h actual %h", $time, want.rank, seen.rank);
          fail_cnt++;
        end
        if (seen.cx !== want.cx) begin
          $display("%0t: coord_x_out expected %h actual %h", $time, want.cx, seen.cx);
          fail_cnt++;
        end
        if (seen.cy !== want.cy) begin
          $display("%0t: coord_y_out expected %h actual %h", $time, want.cy, seen.cy);
          fail_cnt++;
        end
        if (seen.cz !== want.cz) begin
          $display("%0t: coord_z_out expected %h actual %h", $time, want.cz, seen.cz);
          fail_cnt++;
        end
        if (seen.nul !== want.nul) begin
          $display("%0t: null_result expected %b actual %b", $time, want.nul, seen.nul);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    conv_t none;
    conv_t nul_r;
    conv_t zero_r;
    conv_t max_r;
    logic [29:0] gsize;
    logic [29:0] rk;
    int          n_items;
    none   = '{rank: '0, cx: '0, cy: '0, cz: '0, nul: 1'b0};
    zero_r = none;
    nul_r  = none;
    nul_r.nul = 1'b1;
    max_r = '{rank: '0, cx: 10'd1023, cy: 10'd1023, cz: 10'd1023, nul: 1'b0};

    grid_dim[0] = 11'd1; grid_dim[1] = 11'd1; grid_dim[2] = 11'd1;
    wrap_mask = '0;
    order_sel = '0;

    // reset defaults: 1x1x1 grid, no wrap
    add_row(ROW_ITEM, 3'(OP_RANK2COORD), 30'd0, 0, 0, 0, 1, zero_r);
    add_row(ROW_ITEM, 3'(OP_RANK2COORD), 30'd1, 0, 0, 0, 1, nul_r);
    add_row(ROW_ITEM, 3'(OP_RANK2COORD), 30'h3fffffff, 0, 0, 0, 1, nul_r);
    add_row(ROW_ITEM, 3'(OP_COORD2RANK), 30'd0, 0, 0, 0, 1, zero_r);
    add_row(ROW_ITEM, 3'(OP_COORD2RANK), 30'd0, -1, 0, 0, 1, nul_r);
    add_row(ROW_ITEM, 3'(OP_COORD2RANK), 30'd0, 0, 2047, 0, 1, nul_r);
    add_row(ROW_ITEM, 3'(OP_COORD2RANK), 30'd0, 0, 0, -2048, 1, nul_r);
    add_row(ROW_ITEM, 3'(OP_COORD2RANK), 30'd0, 1, 0, 0, 1, nul_r);
    // largest grid, every axis periodic
    add_row(ROW_CFG, REG_DIM_X, 30'd1024, 0, 0, 0, 0, none);
    add_row(ROW_CFG, REG_DIM_Y, 30'd1024, 0, 0, 0, 0, none);
    add_row(ROW_CFG, REG_DIM_Z, 30'd1024, 0, 0, 0, 0, none);
    add_row(ROW_CFG, REG_PERIODIC, 30'd7, 0, 0, 0, 0, none);
    add_row(ROW_ITEM, 3'(OP_RANK2COORD), 30'h3fffffff, 0, 0, 0, 1, max_r);
    add_row(ROW_ITEM, 3'(OP_COORD2RANK), 30'd0, -1, -1, -1, 0, none);
    add_row(ROW_ITEM, 3'(OP_COORD2RANK), 30'd0, 1024, 1024, 1024, 1, zero_r);
    add_row(ROW_ITEM, 3'(OP_COORD2RANK), 30'd0, 1025, 0, 0, 1, nul_r);
    add_row(ROW_ITEM, 3'(OP_COORD2RANK), 30'd0, -2, 0, 0, 1, nul_r);
    // extents that clamp or saturate, unused order code 7, then order code 2
    add_row(ROW_CFG, REG_DIM_X, 30'd0, 0, 0, 0, 0, none);
    add_row(ROW_CFG, REG_DIM_Y, 30'd2047, 0, 0, 0, 0, none);
    add_row(ROW_CFG, REG_DIM_Z, 30'd5, 0, 0, 0, 0, none);
    add_row(ROW_CFG, REG_PERIODIC, 30'd2, 0, 0, 0, 0, none);
    add_row(ROW_CFG, REG_ORDER, 30'd7, 0, 0, 0, 0, none);
    add_row(ROW_ITEM, 3'(OP_RANK2COORD), 30'd4000, 0, 0, 0, 0, none);
    add_row(ROW_ITEM, 3'(OP_COORD2RANK), 30'd0, 0, -1, 4, 0, none);
    add_row(ROW_CFG, REG_ORDER, 30'd2, 0, 0, 0, 0, none);
    add_row(ROW_ITEM, 3'(OP_RANK2COORD), 30'd4000, 0, 0, 0, 0, none);
    add_row(ROW_ITEM, 3'(OP_COORD2RANK), 30'd0, 0, 1024, 5, 0, none);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (steps[i]) begin
      if (steps[i].kind == ROW_CFG) begin
        in_tvalid <= 1'b0;
        write_reg(steps[i].sel, steps[i].rank[10:0]);
      end else begin
        send_item(steps[i].sel[0], steps[i].rank, steps[i].x, steps[i].y, steps[i].z,
                  steps[i].chk, steps[i].res);
      end
    end

    // random phases, each with a fresh configuration
    while (items_sent < 1950) begin
      in_tvalid <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        case ($urandom_range(0, 7))
          0: write_reg(3'(a), 11'd0);
          1: write_reg(3'(a), 11'd1024);
          2: write_reg(3'(a), 11'($urandom_range(1025, 2047)));
          3: write_reg(3'(a), 11'($urandom_range(0, 2047)));
          default: write_reg(3'(a), 11'($urandom_range(1, 16)));
        endcase
      end
      write_reg(REG_PERIODIC, 11'($urandom_range(0, 7)));
      write_reg(REG_ORDER, 11'($urandom_range(0, 7)));
      begin
        longint p;
        p = 1;
        for (int a = 0; a < 3; a++)
          p = p * ((grid_dim[a] == 0) ? longint'(1) :
                   (grid_dim[a] > 1024 ? longint'(1024) : longint'(grid_dim[a])));
        gsize = (p > 30'h3fffffff) ? 30'h3fffffff : p[29:0];
      end
      no_idle = ($urandom_range(0, 3) == 0);
      n_items = $urandom_range(60, 140);
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 1)) begin
          case ($urandom_range(0, 5))
            0: rk = 30'($urandom_range(0, 30'h3fffffff));
            1: rk = gsize;
            2: rk = gsize - 1;
            default: rk = 30'($urandom_range(0, gsize - 1));
          endcase
          send_item(OP_RANK2COORD, rk, 12'($urandom), 12'($urandom), 12'($urandom),
                    0, none);
        end else begin
          send_item(OP_COORD2RANK, 30'($urandom), pick_coord(grid_dim[0]),
                    pick_coord(grid_dim[1]), pick_coord(grid_dim[2]), 0, none);
        end
      end
    end

    in_tvalid <= 1'b0;
    no_idle = 1'b0;
    wait (pending_results.size() == 0);
    repeat (80) @(posedge clk);
    $display("covered %0d items, %0d results, %0d register writes", items_sent,
             results_seen, cfg_writes);
    $display("grid extents incl. saturating ones, all six orders plus unused codes, wrap");
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ cartesian_rank_coord_converter_unit.f @@
rtl/crcc_pkg.sv
rtl/crcc_cell.sv
rtl/cartesian_rank_coord_converter_unit.sv
test/tb_cartesian_rank_coord_converter_unit.sv
